[hdl/fsme_pkg.sv]
// ----------------------------------------------------------------------------
// fsme_pkg
// Shared types, codes and defaults of the table-driven fsm engine.
// ----------------------------------------------------------------------------
package fsme_pkg;

  // defaults for the top-level parameters
  localparam int STATES_DEF = 16;
  localparam int SLOTS_DEF  = 8;

  // guard vector size, fixed by the guard_values field
  localparam int GUARDS = 8;

  // field widths
  localparam int EVENT_W  = 6;
  localparam int STATE_W  = 4;
  localparam int SLOT_W   = 3;
  localparam int GIDX_W   = 3;
  localparam int CNT_W    = 4;
  localparam int SCOUNT_W = 5;
  localparam int STATUS_W = 3;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 5;
  localparam logic [CFG_IW-1:0] CFG_ENABLED = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_START   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_COUNT   = 2'd2;

  localparam logic [SCOUNT_W-1:0] STATE_COUNT_RST = 5'd16;

  // request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  localparam logic [EVENT_W-1:0] NULL_EVENT = '0;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED = 3'd0,
    ST_NOMATCH = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_INVALID = 3'd3,
    ST_FIRED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CNT,
    SEQ_SCAN,
    SEQ_DONE
  } seq_t;

  // one transition slot as stored in the table memory
  typedef struct packed {
    logic               guard_polarity;
    logic [GIDX_W-1:0]  guard_index;
    logic               guard_used;
    logic [STATE_W-1:0] target_state;
    logic [EVENT_W-1:0] event_code;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               kind;
    logic [EVENT_W-1:0] event_code;
    logic [STATE_W-1:0] state_index;
    logic [SLOT_W-1:0]  slot_index;
    logic [STATE_W-1:0] target_state;
    logic               guard_used;
    logic [GIDX_W-1:0]  guard_index;
    logic               guard_polarity;
    logic [CNT_W-1:0]   slot_count;
    logic [GUARDS-1:0]  guard_values;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [SLOT_W-1:0]  slot_taken;
    logic               state_changed;
  } out_item_t;

  typedef struct packed {
    logic                enabled;
    logic [SCOUNT_W-1:0] state_count;
  } cfg_t;

  // current-state update from the sequencer
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] state;
  } upd_t;

endpackage

[hdl/fsme_if.sv]
// ----------------------------------------------------------------------------
// fsme_in_if / fsme_out_if
// Valid/ready channels carrying requests into and results out of the engine.
// ----------------------------------------------------------------------------
interface fsme_in_if;
  import fsme_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [EVENT_W-1:0]  event_code;
  logic [STATE_W-1:0]  state_index;
  logic [SLOT_W-1:0]   slot_index;
  logic [STATE_W-1:0]  target_state;
  logic                guard_used;
  logic [GIDX_W-1:0]   guard_index;
  logic                guard_polarity;
  logic [CNT_W-1:0]    slot_count;
  logic [GUARDS-1:0]   guard_values;

  modport source (
    output valid, kind, event_code, state_index, slot_index, target_state,
           guard_used, guard_index, guard_polarity, slot_count, guard_values,
    input  ready
  );

  modport sink (
    input  valid, kind, event_code, state_index, slot_index, target_state,
           guard_used, guard_index, guard_polarity, slot_count, guard_values,
    output ready
  );
endinterface

interface fsme_out_if;
  import fsme_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [STATE_W-1:0]  from_state;
  logic [STATE_W-1:0]  to_state;
  logic [SLOT_W-1:0]   slot_taken;
  logic                state_changed;

  modport source (
    output valid, status, from_state, to_state, slot_taken, state_changed,
    input  ready
  );

  modport sink (
    input  valid, status, from_state, to_state, slot_taken, state_changed,
    output ready
  );
endinterface

[hdl/table_driven_fsm_engine_core.sv]
// ----------------------------------------------------------------------------
// table_driven_fsm_engine_core
// Programmable fsm engine with guarded transition slots held in memory.
// ----------------------------------------------------------------------------
// A load request writes one transition slot and the state's slot count; it
// gives no result. An event request reads the current state's slot count
// (at most SLOTS), then scans that state's slots in order, stopping early
// when a slot fires or hits an invalid target; an ignored event skips the
// scan. The transition table memory delivers one slot per cycle to the
// scan. A new request is taken once the previous event has moved its
// result into the output register, even if that result is still waiting
// downstream. Configuration is written through cfg_we/cfg_index/cfg_data
// while the engine is idle; writing enabled from 0 to 1 loads the current
// state from start_state.
module table_driven_fsm_engine_core #(
  parameter int STATES = fsme_pkg::STATES_DEF,
  parameter int SLOTS  = fsme_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fsme_in_if.sink                      in_ch,
  fsme_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [fsme_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [fsme_pkg::CFG_DW-1:0]  cfg_data
);
  import fsme_pkg::*;

  localparam int TA = $clog2(STATES*SLOTS);
  localparam int CA = $clog2(STATES);

  logic                enabled_r, enabled_nxt;
  logic [STATE_W-1:0]  start_r, start_nxt;
  logic [SCOUNT_W-1:0] count_r, count_nxt;
  logic [STATE_W-1:0]  cur_r, cur_nxt;

  in_item_t  in_item;
  out_item_t out_item;
  cfg_t      cfg;
  upd_t      upd;

  logic            tbl_we;
  logic [TA-1:0]   tbl_waddr;
  entry_t          tbl_wdata;
  logic [TA-1:0]   tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rbits;
  logic            cnt_we;
  logic [CA-1:0]   cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic [CA-1:0]   cnt_raddr;
  logic [CNT_W-1:0] cnt_rdata;

  assign in_item = '{kind:           in_ch.kind,
                     event_code:     in_ch.event_code,
                     state_index:    in_ch.state_index,
                     slot_index:     in_ch.slot_index,
                     target_state:   in_ch.target_state,
                     guard_used:     in_ch.guard_used,
                     guard_index:    in_ch.guard_index,
                     guard_polarity: in_ch.guard_polarity,
                     slot_count:     in_ch.slot_count,
                     guard_values:   in_ch.guard_values};

  assign out_ch.status        = out_item.status;
  assign out_ch.from_state    = out_item.from_state;
  assign out_ch.to_state      = out_item.to_state;
  assign out_ch.slot_taken    = out_item.slot_taken;
  assign out_ch.state_changed = out_item.state_changed;

  assign cfg = '{enabled: enabled_r, state_count: count_r};

  // configuration and current state
  always_comb begin
    enabled_nxt = enabled_r;
    start_nxt   = start_r;
    count_nxt   = count_r;
    cur_nxt     = upd.valid ? upd.state : cur_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED: begin
          enabled_nxt = cfg_data[0];
          if (cfg_data[0] && !enabled_r) begin
            cur_nxt = start_r;
          end
        end
        CFG_START: start_nxt = cfg_data[STATE_W-1:0];
        CFG_COUNT: count_nxt = cfg_data[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      start_r   <= '0;
      count_r   <= STATE_COUNT_RST;
      cur_r     <= '0;
    end else begin
      enabled_r <= enabled_nxt;
      start_r   <= start_nxt;
      count_r   <= count_nxt;
      cur_r     <= cur_nxt;
    end
  end

  fsme_ram #(
    .W (ENTRY_W),
    .D (STATES*SLOTS)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rbits)
  );

  fsme_ram #(
    .W (CNT_W),
    .D (STATES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  fsme_scan #(
    .STATES (STATES),
    .SLOTS  (SLOTS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cfg       (cfg),
    .cur_state (cur_r),
    .upd       (upd),
    .out_item  (out_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (entry_t'(tbl_rbits)),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_raddr (cnt_raddr),
    .cnt_rdata (cnt_rdata)
  );

endmodule

[hdl/fsme_ram.sv]
// ----------------------------------------------------------------------------
// fsme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsme_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/fsme_scan.sv]
// ----------------------------------------------------------------------------
// fsme_scan
// Request sequencer: writes loaded slots, scans the current state's slots
// one memory read per slot and holds the result register.
// ----------------------------------------------------------------------------
module fsme_scan #(
  parameter int STATES = fsme_pkg::STATES_DEF,
  parameter int SLOTS  = fsme_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fsme_pkg::in_item_t                in_item,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fsme_pkg::cfg_t                    cfg,
  input  logic [fsme_pkg::STATE_W-1:0]      cur_state,
  output fsme_pkg::upd_t                    upd,
  output fsme_pkg::out_item_t               out_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              tbl_we,
  output logic [$clog2(STATES*SLOTS)-1:0]   tbl_waddr,
  output fsme_pkg::entry_t                  tbl_wdata,
  output logic [$clog2(STATES*SLOTS)-1:0]   tbl_raddr,
  input  fsme_pkg::entry_t                  tbl_rdata,
  output logic                              cnt_we,
  output logic [$clog2(STATES)-1:0]         cnt_waddr,
  output logic [fsme_pkg::CNT_W-1:0]        cnt_wdata,
  output logic [$clog2(STATES)-1:0]         cnt_raddr,
  input  logic [fsme_pkg::CNT_W-1:0]        cnt_rdata
);
  import fsme_pkg::*;

  localparam int TA = $clog2(STATES*SLOTS);
  localparam int CA = $clog2(STATES);

  seq_t               seq_r, seq_nxt;
  logic [EVENT_W-1:0] ev_r;
  logic [GUARDS-1:0]  guard_r;
  logic [STATE_W-1:0] from_r;
  logic [STATE_W-1:0] to_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   i_r;
  logic               blocked_r;
  status_t            status_r;
  logic [SLOT_W-1:0]  taken_r;
  logic               changed_r;
  logic [STATES-1:0]  cnt_vld_r;
  logic               vld_q_r;
  out_item_t          out_item_r;
  logic               out_valid_r;

  logic             accept;
  logic             is_load;
  logic             st_ok;
  logic             sl_ok;
  logic             ignore;
  logic [CNT_W-1:0] n_load;
  logic             match;
  logic             tgt_bad;
  logic             gbit;
  logic             permit;
  logic             last;
  logic             blocked_now;
  logic             done_go;
  logic [CNT_W-1:0] slot_next;

  assign accept  = in_valid && in_ready;
  assign is_load = (in_item.kind == KIND_LOAD);
  assign st_ok   = int'(in_item.state_index) < STATES;
  assign sl_ok   = int'(in_item.slot_index) < SLOTS;
  assign ignore  = !cfg.enabled || (in_item.event_code == NULL_EVENT) ||
                   !({1'b0, cur_state} < cfg.state_count) ||
                   !(int'(cur_state) < STATES);

  // a state never loaded has zero slots
  assign n_load = vld_q_r ? cnt_rdata : '0;

  assign match       = (tbl_rdata.event_code == ev_r);
  assign tgt_bad     = !({1'b0, tbl_rdata.target_state} < cfg.state_count);
  assign gbit        = (int'(tbl_rdata.guard_index) < GUARDS) ?
                       guard_r[tbl_rdata.guard_index] : 1'b0;
  assign permit      = !tbl_rdata.guard_used || (gbit ^ tbl_rdata.guard_polarity);
  assign last        = ((i_r + 1'b1) == n_r);
  assign blocked_now = blocked_r || (match && !tgt_bad && !permit);
  assign done_go     = (seq_r == SEQ_DONE) && (!out_valid_r || out_ready);
  assign slot_next   = (seq_r == SEQ_CNT) ? '0 : i_r + 1'b1;

  // next state
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      SEQ_IDLE: begin
        if (accept && !is_load) begin
          seq_nxt = ignore ? SEQ_DONE : SEQ_CNT;
        end
      end
      SEQ_CNT: begin
        seq_nxt = (n_load == '0) ? SEQ_DONE : SEQ_SCAN;
      end
      SEQ_SCAN: begin
        if ((match && (tgt_bad || permit)) || last) begin
          seq_nxt = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (done_go) begin
          seq_nxt = SEQ_IDLE;
        end
      end
      default: seq_nxt = SEQ_IDLE;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    in_ready  = 1'b0;
    upd       = '0;
    tbl_we    = 1'b0;
    cnt_we    = 1'b0;
    tbl_waddr = TA'(int'(in_item.state_index) * SLOTS + int'(in_item.slot_index));
    tbl_wdata = '{guard_polarity: in_item.guard_polarity,
                  guard_index:    in_item.guard_index,
                  guard_used:     in_item.guard_used,
                  target_state:   in_item.target_state,
                  event_code:     in_item.event_code};
    cnt_waddr = CA'(int'(in_item.state_index));
    cnt_wdata = (int'(in_item.slot_count) > SLOTS) ? CNT_W'(SLOTS) : in_item.slot_count;
    cnt_raddr = CA'(int'(cur_state));
    tbl_raddr = TA'(int'(from_r) * SLOTS + int'(slot_next));
    case (seq_r)
      SEQ_IDLE: begin
        in_ready = 1'b1;
        tbl_we   = in_valid && is_load && st_ok && sl_ok;
        cnt_we   = in_valid && is_load && st_ok;
      end
      SEQ_DONE: begin
        upd.valid = done_go && (status_r == ST_FIRED);
        upd.state = to_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SEQ_IDLE;
      out_valid_r <= 1'b0;
      cnt_vld_r   <= '0;
    end else begin
      seq_r <= seq_nxt;
      if (cnt_we) begin
        cnt_vld_r[cnt_waddr] <= 1'b1;
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    vld_q_r <= cnt_vld_r[cnt_raddr];
    if (done_go) begin
      out_item_r <= '{status:        status_r,
                      from_state:    from_r,
                      to_state:      to_r,
                      slot_taken:    taken_r,
                      state_changed: changed_r};
    end
    case (seq_r)
      SEQ_IDLE: begin
        if (accept) begin
          ev_r      <= in_item.event_code;
          guard_r   <= in_item.guard_values;
          from_r    <= cur_state;
          to_r      <= cur_state;
          status_r  <= ST_IGNORED;
          blocked_r <= 1'b0;
          taken_r   <= '0;
          changed_r <= 1'b0;
        end
      end
      SEQ_CNT: begin
        status_r <= ST_NOMATCH;
        n_r      <= n_load;
        i_r      <= '0;
      end
      SEQ_SCAN: begin
        blocked_r <= blocked_now;
        i_r       <= i_r + 1'b1;
        if (match && tgt_bad) begin
          status_r <= ST_INVALID;
        end else if (match && permit) begin
          status_r  <= ST_FIRED;
          taken_r   <= SLOT_W'(i_r);
          to_r      <= tbl_rdata.target_state;
          changed_r <= (tbl_rdata.target_state != from_r);
        end else if (last) begin
          status_r <= blocked_now ? ST_BLOCKED : ST_NOMATCH;
        end
      end
      default: ;
    endcase
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

endmodule

[hdl/fsme_checker.sv]
// ----------------------------------------------------------------------------
// fsme_checker
// Port-level checks of the fsm engine, bound to the top level.
// ----------------------------------------------------------------------------
module fsme_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_kind,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [fsme_pkg::STATUS_W-1:0]  out_status,
  input logic [fsme_pkg::STATE_W-1:0]   out_from,
  input logic [fsme_pkg::STATE_W-1:0]   out_to,
  input logic [fsme_pkg::SLOT_W-1:0]    out_slot,
  input logic                           out_changed
);
  import fsme_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_status, out_from, out_to, out_slot, out_changed}))
    else $error("stalled result changed");

  // only a fired transition moves the state or names a slot
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FIRED) |->
      (out_from == out_to) && (out_slot == '0) && !out_changed)
    else $error("non-fired result moved state");

  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FIRED) |-> out_changed == (out_from != out_to))
    else $error("state_changed disagrees with from/to");

  // a load request never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_LOAD) && !out_valid |=> !out_valid)
    else $error("result after load request");

  // after an event request is taken, in_ready drops while the engine is busy with it
  a_event_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_EVENT) |=> !in_ready)
    else $error("request taken during event scan");

endmodule

bind table_driven_fsm_engine_core fsme_checker u_fsme_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_kind     (in_ch.kind),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_from    (out_ch.from_state),
  .out_to      (out_ch.to_state),
  .out_slot    (out_ch.slot_taken),
  .out_changed (out_ch.state_changed)
);

[tb/sv/fsme_outcome_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsme_outcome_checker
// Watches the request, result and configuration ports of the fsm engine,
// keeps its own copy of the transition table and current state, predicts
// the outcome of every event request and compares it with the result seen.
// ----------------------------------------------------------------------------
module fsme_outcome_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  fsme_in_if                            in_ch,
  fsme_out_if                           out_ch,
  input  logic                          cfg_we,
  input  logic [fsme_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [fsme_pkg::CFG_DW-1:0]   cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import fsme_pkg::*;

  localparam int NST = STATES_DEF;
  localparam int NSL = SLOTS_DEF;

  entry_t              slot_table [NST][NSL];
  logic [CNT_W-1:0]    slot_cnt [NST];
  logic [STATE_W-1:0]  cur_state;
  logic                eng_en;
  logic [STATE_W-1:0]  start_st;
  logic [SCOUNT_W-1:0] n_states;
  out_item_t           expected_outcomes [$];
  int                  n_fail;

  task automatic write_engine_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] d);
    case (idx)
      CFG_ENABLED: begin
        // activation reloads the current state
        if (d[0] && !eng_en) cur_state = start_st;
        eng_en = d[0];
      end
      CFG_START: start_st = d[STATE_W-1:0];
      CFG_COUNT: n_states = d;
      default: ;
    endcase
  endtask

  task automatic step_engine(input in_item_t r);
    entry_t    e;
    int        n;
    logic      blocked;
    logic      done;
    out_item_t res;
    if (r.kind == KIND_LOAD) begin
      slot_table[r.state_index][r.slot_index] = {r.guard_polarity, r.guard_index,
                                                 r.guard_used, r.target_state,
                                                 r.event_code};
      slot_cnt[r.state_index] = (r.slot_count > NSL) ? CNT_W'(NSL) : r.slot_count;
    end else begin
      res.status        = ST_IGNORED;
      res.from_state    = cur_state;
      res.to_state      = cur_state;
      res.slot_taken    = '0;
      res.state_changed = 1'b0;
      if (eng_en && r.event_code != NULL_EVENT && SCOUNT_W'(cur_state) < n_states) begin
        n       = int'(slot_cnt[cur_state]);
        blocked = 1'b0;
        done    = 1'b0;
        res.status = ST_NOMATCH;
        for (int i = 0; i < n; i++) begin
          e = slot_table[cur_state][i];
          if (!done && e.event_code == r.event_code) begin
            if (SCOUNT_W'(e.target_state) >= n_states) begin
              // invalid target stops the scan, even after blocked matches
              res.status = ST_INVALID;
              done = 1'b1;
            end else if (e.guard_used &&
                         !(r.guard_values[e.guard_index] ^ e.guard_polarity)) begin
              blocked = 1'b1;
            end else begin
              res.status        = ST_FIRED;
              res.slot_taken    = i[SLOT_W-1:0];
              res.state_changed = (e.target_state != cur_state);
              res.to_state      = e.target_state;
              cur_state         = e.target_state;
              done = 1'b1;
            end
          end
        end
        if (res.status == ST_NOMATCH && blocked) res.status = ST_BLOCKED;
      end
      expected_outcomes.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    in_item_t  req;
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) begin
        slot_cnt[s] = '0;
        for (int k = 0; k < NSL; k++) slot_table[s][k] = '0;
      end
      cur_state = '0;
      eng_en    = 1'b0;
      start_st  = '0;
      n_states  = STATE_COUNT_RST;
      n_fail    = 0;
      expected_outcomes.delete();
    end else begin
      if (cfg_we) write_engine_reg(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready) begin
        req.kind           = in_ch.kind;
        req.event_code     = in_ch.event_code;
        req.state_index    = in_ch.state_index;
        req.slot_index     = in_ch.slot_index;
        req.target_state   = in_ch.target_state;
        req.guard_used     = in_ch.guard_used;
        req.guard_index    = in_ch.guard_index;
        req.guard_polarity = in_ch.guard_polarity;
        req.slot_count     = in_ch.slot_count;
        req.guard_values   = in_ch.guard_values;
        step_engine(req);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status        = status_t'(out_ch.status);
        got.from_state    = out_ch.from_state;
        got.to_state      = out_ch.to_state;
        got.slot_taken    = out_ch.slot_taken;
        got.state_changed = out_ch.state_changed;
        if (expected_outcomes.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: unexpected result status=%0d from=%0d to=%0d slot=%0d changed=%0d",
                     $time, got.status, got.from_state, got.to_state, got.slot_taken,
                     got.state_changed);
          n_fail++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got.status != want.status || got.from_state != want.from_state ||
              got.to_state != want.to_state || got.slot_taken != want.slot_taken ||
              got.state_changed != want.state_changed) begin
            if (n_fail < 10)
              $display({"%0t: result mismatch: expected status=%0d from=%0d to=%0d slot=%0d ",
                        "changed=%0d, got status=%0d from=%0d to=%0d slot=%0d changed=%0d"},
                       $time, want.status, want.from_state, want.to_state, want.slot_taken,
                       want.state_changed, got.status, got.from_state, got.to_state,
                       got.slot_taken, got.state_changed);
            n_fail++;
          end
        end
      end
    end
    fail_count <= n_fail;
    pending    <= expected_outcomes.size();
  end

endmodule

[tb/sv/tb_table_driven_fsm_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_driven_fsm_engine_core
// Drives slot loads, events and register writes into the fsm engine with
// random request gaps and result stalls; the outcome checker beside the
// engine predicts every result; failures and pending results decide the verdict.
// ----------------------------------------------------------------------------
module tb_table_driven_fsm_engine_core;
  import fsme_pkg::*;

  localparam int RAND_ITEMS = 1650;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;
  int                  fail_count;
  int                  pending;

  fsme_in_if  in_ch ();
  fsme_out_if out_ch ();

  table_driven_fsm_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fsme_outcome_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // slots loaded so far; a state's slot count never reaches past them
  bit                  written [STATES_DEF][SLOTS_DEF];
  logic [SCOUNT_W-1:0] cur_count;
  logic                cur_en;
  int                  burst_left;
  int                  rx_mode;
  int                  rx_mode_left;
  int                  rx_run;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #8_000_000;
    $display("tb_table_driven_fsm_engine_core NOT OK");
    $finish;
  end

  // result stalls: always ready, random, or long runs low
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode      <= 0;
      rx_mode_left <= 0;
      rx_run       <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(50, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 9) < 7);
        default: begin
          if (rx_run == 0) begin
            out_ch.ready <= ~out_ch.ready;
            rx_run <= out_ch.ready ? $urandom_range(1, 15) : $urandom_range(1, 4);
          end else begin
            rx_run <= rx_run - 1;
          end
        end
      endcase
    end
  end

  function automatic in_item_t rand_fields();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [EVENT_W-1:0] pick_code();
    int p;
    p = $urandom_range(0, 99);
    if (p < 85) return EVENT_W'($urandom_range(1, 6));
    else if (p < 93) return EVENT_W'($urandom_range(0, 63));
    else return NULL_EVENT;
  endfunction

  task automatic send_req(input in_item_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 24);
    end
    in_ch.kind           <= r.kind;
    in_ch.event_code     <= r.event_code;
    in_ch.state_index    <= r.state_index;
    in_ch.slot_index     <= r.slot_index;
    in_ch.target_state   <= r.target_state;
    in_ch.guard_used     <= r.guard_used;
    in_ch.guard_index    <= r.guard_index;
    in_ch.guard_polarity <= r.guard_polarity;
    in_ch.slot_count     <= r.slot_count;
    in_ch.guard_values   <= r.guard_values;
    in_ch.valid          <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  // cnt below zero picks a count inside the loaded prefix, or an oversized one once every slot is loaded
  task automatic send_load(input in_item_t r, input int cnt);
    int p;
    written[r.state_index][r.slot_index] = 1'b1;
    p = 0;
    while (p < SLOTS_DEF && written[r.state_index][p]) p++;
    if (cnt < 0) begin
      if (p == SLOTS_DEF && $urandom_range(0, 3) == 0) cnt = $urandom_range(SLOTS_DEF + 1, 15);
      else if ($urandom_range(0, 9) < 7) cnt = p;
      else cnt = $urandom_range(0, p);
    end
    r.kind       = KIND_LOAD;
    r.slot_count = CNT_W'(cnt);
    send_req(r);
  endtask

  task automatic dir_load(input int s, input int sl, input int ev, input int tgt,
                          input bit gu, input int gi, input bit gp, input int cnt);
    in_item_t r;
    r = rand_fields();
    r.state_index    = STATE_W'(s);
    r.slot_index     = SLOT_W'(sl);
    r.event_code     = EVENT_W'(ev);
    r.target_state   = STATE_W'(tgt);
    r.guard_used     = gu;
    r.guard_index    = GIDX_W'(gi);
    r.guard_polarity = gp;
    send_load(r, cnt);
  endtask

  task automatic rand_load(input int s, input int sl);
    in_item_t r;
    r = rand_fields();
    r.state_index  = STATE_W'(s);
    r.slot_index   = SLOT_W'(sl);
    r.event_code   = pick_code();
    r.target_state = ($urandom_range(0, 9) < 8) ? STATE_W'($urandom_range(0, cur_count - 1))
                                                : STATE_W'($urandom_range(0, 15));
    send_load(r, -1);
  endtask

  task automatic send_event(input logic [EVENT_W-1:0] code, input logic [GUARDS-1:0] gv);
    in_item_t r;
    r = rand_fields();
    r.kind         = KIND_EVENT;
    r.event_code   = code;
    r.guard_values = gv;
    send_req(r);
  endtask

  // stop requesting and let every result and any load in flight finish
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] d);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_we    <= 1'b1;
    if (idx == CFG_COUNT) cur_count = d;
    if (idx == CFG_ENABLED) cur_en = d[0];
    @(posedge clk);
  endtask

  task automatic reconfigure();
    int m;
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_COUNT, CFG_DW'(1));
        1:       write_reg(CFG_COUNT, CFG_DW'(16));
        default: write_reg(CFG_COUNT, CFG_DW'($urandom_range(1, 16)));
      endcase
    end
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_START, ($urandom_range(0, 1) == 1) ? CFG_DW'($urandom_range(0, cur_count - 1))
                                                       : CFG_DW'($urandom_range(0, 15)));
    m = $urandom_range(0, 19);
    if (m < 2) begin
      write_reg(CFG_ENABLED, CFG_DW'(0));
    end else if (m < 3) begin
      write_reg(CFG_ENABLED, CFG_DW'(1));
    end else begin
      write_reg(CFG_ENABLED, CFG_DW'(0));
      write_reg(CFG_ENABLED, CFG_DW'(1));
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stim
    int                 rand_items;
    int                 n_st;
    int                 n_sl;
    int                 n_ev;
    logic [STATE_W-1:0] s;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_ENABLED;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.kind           = KIND_LOAD;
    in_ch.event_code     = '0;
    in_ch.state_index    = '0;
    in_ch.slot_index     = '0;
    in_ch.target_state   = '0;
    in_ch.guard_used     = 1'b0;
    in_ch.guard_index    = '0;
    in_ch.guard_polarity = 1'b0;
    in_ch.slot_count     = '0;
    in_ch.guard_values   = '0;
    burst_left           = 0;
    cur_count            = STATE_COUNT_RST;
    cur_en               = 1'b0;
    for (int i = 0; i < STATES_DEF; i++)
      for (int k = 0; k < SLOTS_DEF; k++) written[i][k] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // event while disabled
    send_event(EVENT_W'(5), 8'h00);
    // state 0 table: self loop, two guarded slots on one event, far targets,
    // a blocked slot ahead of an invalid one, oversized count on the last load
    dir_load(0, 0, 1,  0,  0, 0, 0, 1);
    dir_load(0, 1, 2,  5,  1, 7, 0, 2);
    dir_load(0, 2, 2,  6,  1, 0, 1, 3);
    dir_load(0, 3, 3,  12, 0, 0, 0, 4);
    dir_load(0, 4, 63, 15, 0, 0, 0, 5);
    dir_load(0, 5, 5,  1,  1, 3, 0, 6);
    dir_load(0, 6, 5,  13, 0, 0, 0, 7);
    dir_load(0, 7, 4,  1,  0, 0, 0, 15);
    wait_drained();
    write_reg(CFG_ENABLED, CFG_DW'(1));
    cfg_we <= 1'b0;
    send_event(NULL_EVENT, 8'hff);
    send_event(EVENT_W'(9), 8'h00);
    send_event(EVENT_W'(1), 8'h00);
    send_event(EVENT_W'(2), 8'h01);
    send_event(EVENT_W'(63), 8'h55);
    send_event(EVENT_W'(1), 8'haa);
    // fewer valid states, reactivate at state 0
    wait_drained();
    write_reg(CFG_COUNT, CFG_DW'(12));
    write_reg(CFG_ENABLED, CFG_DW'(0));
    write_reg(CFG_ENABLED, CFG_DW'(1));
    cfg_we <= 1'b0;
    send_event(EVENT_W'(3), 8'h00);
    send_event(EVENT_W'(5), 8'h00);
    send_event(EVENT_W'(2), 8'h80);
    // start state outside the valid range
    wait_drained();
    write_reg(CFG_START, CFG_DW'(15));
    write_reg(CFG_ENABLED, CFG_DW'(0));
    write_reg(CFG_ENABLED, CFG_DW'(1));
    cfg_we <= 1'b0;
    send_event(EVENT_W'(1), 8'h00);
    wait_drained();
    write_reg(CFG_COUNT, CFG_DW'(16));
    cfg_we <= 1'b0;
    send_event(EVENT_W'(1), 8'h00);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_drained();
      reconfigure();
      n_st = $urandom_range(0, 3);
      repeat (n_st) begin
        s = ($urandom_range(0, 9) < 7) ? STATE_W'($urandom_range(0, cur_count - 1))
                                       : STATE_W'($urandom_range(0, 15));
        n_sl = $urandom_range(1, SLOTS_DEF);
        for (int k = 0; k < n_sl; k++) begin
          rand_load(s, k);
          rand_items++;
        end
      end
      n_ev = cur_en ? $urandom_range(15, 60) : $urandom_range(3, 10);
      repeat (n_ev) begin
        if ($urandom_range(0, 15) == 0) begin
          rand_load($urandom_range(0, 15), $urandom_range(0, SLOTS_DEF - 1));
          rand_items++;
        end else begin
          send_event(pick_code(), GUARDS'($urandom));
          if (cur_en) rand_items++;
        end
      end
    end

    wait_drained();
    repeat (32) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_table_driven_fsm_engine_core OK");
    end else begin
      $display("tb_table_driven_fsm_engine_core NOT OK");
    end
    $finish;
  end

endmodule
